// ===== sv/pfp_pkg.sv =====
package pfp_pkg;

   typedef enum logic [2:0] {
      ACT_SET   = 3'd0,
      ACT_CLR   = 3'd1,
      ACT_CLALL = 3'd2,
      ACT_CIRC  = 3'd3,
      ACT_READ  = 3'd4
   } action_type;

   // one classified command between front and back
   typedef struct packed {
      logic [2:0] action;
      logic [6:0] x_pos;
      logic [5:0] y_pos;
      logic [5:0] radius;
      logic [2:0] page_sel;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PIX_RD,
      ST_PIX_WR,
      ST_CLEAR,
      ST_CIRC_PT,
      ST_CIRC_WR,
      ST_CIRC_STEP,
      ST_DONE
   } state_type;

endpackage

// ===== sv/pfp_front.sv =====
module pfp_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  pfp_pkg::cmd_type req_cmd,
   output logic             cmd_valid,
   input  logic             cmd_take,
   output pfp_pkg::cmd_type cmd_out
);
   import pfp_pkg::*;

   // two-entry command queue
   cmd_type    q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic       do_push, do_pop;

   assign req_full  = (cnt_ff == 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd_out   = q_ff[rd_ff];
   assign do_push   = req_push && !req_full;
   assign do_pop    = cmd_take && cmd_valid;

   always_comb begin
      cnt_in = cnt_ff + 2'(do_push) - 2'(do_pop);
      rd_in  = rd_ff ^ do_pop;
      wr_in  = wr_ff ^ do_push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ff] <= req_cmd;
      end
   end

   property p_no_overflow;
      @(posedge clock) disable iff (reset) cnt_ff <= 2'd2;
   endproperty
   a_no_overflow: assert property (p_no_overflow) else $error("queue count overflow");

   property p_full_holds;
      @(posedge clock) disable iff (reset) (req_full && !do_pop) |=> req_full;
   endproperty
   a_full_holds: assert property (p_full_holds) else $error("full dropped without pop");

   property p_pop_moves;
      @(posedge clock) disable iff (reset) (do_pop && !do_push) |=> cnt_ff == $past(cnt_ff) - 2'd1;
   endproperty
   a_pop_moves: assert property (p_pop_moves) else $error("pop count error");
endmodule

// ===== sv/pfp_back.sv =====
module pfp_back #(
   parameter int NUM_COLUMNS = 128,
   parameter int NUM_PAGES   = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_take,
   input  pfp_pkg::cmd_type cmd_in,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output logic [7:0]       rsp_read_data,
   output logic             rsp_clipped
);
   import pfp_pkg::*;

   localparam int CW    = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
   localparam int PW    = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
   localparam int AW    = CW + PW;
   localparam int DEPTH = 2 ** AW;

   logic [7:0] mem [DEPTH];
   logic [7:0] rdat_ff;

   state_type  st_ff, st_in;
   cmd_type    cmd_ff;
   logic [AW-1:0] clr_ff;
   logic       clr_done;
   logic       init_ff;

   // circle walk registers
   logic signed [7:0]  a_ff, b_ff;
   logic [2:0]         oct_ff;
   logic               clip_ff;
   logic signed [9:0]  px, py;
   logic signed [9:0]  xs, ys, as10, bs10;
   logic               on_scr;
   logic [AW-1:0]      addr;
   logic [7:0]         bitm;
   logic               mem_we;
   logic [AW-1:0]      we_addr;
   logic [7:0]         we_data;
   logic [AW-1:0]      rd_addr;

   // result register (skid)
   logic       out_v_ff;
   logic [7:0] out_d_ff;
   logic       out_c_ff;

   logic signed [15:0] a1sq, bsq, rsq;
   logic signed [7:0]  a1;
   logic               circ_end;
   logic               circ_stop;

   assign rsp_empty     = !out_v_ff;
   assign rsp_read_data = out_d_ff;
   assign rsp_clipped   = out_c_ff;

   assign xs   = signed'({3'b000, cmd_ff.x_pos});
   assign ys   = signed'({4'b0000, cmd_ff.y_pos});
   assign as10 = 10'(a_ff);
   assign bs10 = 10'(b_ff);

   // point selection for current octant of the mirror set, or the command's own pixel or read byte
   always_comb begin
      px = 10'sd0;
      py = 10'sd0;
      case (oct_ff)
         3'd0: begin px = xs + as10; py = ys - bs10; end
         3'd1: begin px = xs - as10; py = ys - bs10; end
         3'd2: begin px = xs - as10; py = ys + bs10; end
         3'd3: begin px = xs + as10; py = ys + bs10; end
         3'd4: begin px = xs + bs10; py = ys + as10; end
         3'd5: begin px = xs + bs10; py = ys - as10; end
         3'd6: begin px = xs - bs10; py = ys - as10; end
         default: begin px = xs - bs10; py = ys + as10; end
      endcase
      if (st_ff inside {ST_PIX_RD, ST_PIX_WR, ST_DONE}) begin
         px = xs;
         py = ys;
         // byte read addresses the page directly
         if (cmd_ff.action == ACT_READ) py = signed'(10'({cmd_ff.page_sel, 3'b000}));
      end
      on_scr = (px >= 0) && (py >= 0) && (px < NUM_COLUMNS) &&
               ((py >>> 3) < NUM_PAGES);
      addr   = AW'({px[CW-1:0], PW'(py >>> 3)});
      bitm   = 8'(1) << py[2:0];
   end

   assign a1   = a_ff + 8'sd1;
   assign a1sq = a1 * a1;
   assign bsq  = b_ff * b_ff;
   assign rsq  = $signed({10'd0, cmd_ff.radius}) * $signed({10'd0, cmd_ff.radius});
   assign circ_end = (bsq <<< 1) < rsq;
   assign clr_done = (clr_ff == AW'(DEPTH - 1));

   // loop end test before each set of eight points
   assign circ_stop = (st_ff == ST_CIRC_PT) && (oct_ff == 3'd0) &&
                      (cmd_ff.radius != 6'd0) && circ_end;

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE: if (cmd_valid && !out_v_ff) begin
            st_in = ST_DONE;
            if (cmd_in.action == ACT_SET || cmd_in.action == ACT_CLR ||
                cmd_in.action == ACT_READ) st_in = ST_PIX_RD;
            else if (cmd_in.action == ACT_CLALL) st_in = ST_CLEAR;
            else if (cmd_in.action == ACT_CIRC) st_in = ST_CIRC_PT;
         end
         ST_PIX_RD:   st_in = (cmd_ff.action == ACT_READ) ? ST_DONE : ST_PIX_WR;
         ST_PIX_WR:   st_in = ST_DONE;
         ST_CLEAR:    if (clr_done) st_in = ST_DONE;
         ST_CIRC_PT: begin
            if (circ_stop) st_in = ST_DONE;
            else st_in = on_scr ? ST_CIRC_WR : ST_CIRC_STEP;
         end
         ST_CIRC_WR:  st_in = ST_CIRC_STEP;
         ST_CIRC_STEP: begin
            if (cmd_ff.radius == 6'd0 || oct_ff == 3'd7) begin
               st_in = ST_CIRC_PT;
               if (cmd_ff.radius == 6'd0) st_in = ST_DONE;
            end else st_in = ST_CIRC_PT;
         end
         ST_DONE:     st_in = ST_IDLE;
         default:     st_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      cmd_take = (st_ff == ST_IDLE) && cmd_valid && !out_v_ff;
      rd_addr  = addr;
      mem_we   = 1'b0;
      we_addr  = addr;
      we_data  = rdat_ff | bitm;
      unique case (st_ff)
         ST_PIX_WR: begin
            mem_we  = on_scr;
            we_data = (cmd_ff.action == ACT_SET) ? (rdat_ff | bitm) : (rdat_ff & ~bitm);
         end
         ST_CIRC_WR: mem_we = 1'b1;
         ST_CLEAR: begin
            mem_we  = 1'b1;
            we_addr = clr_ff;
            we_data = 8'h00;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[we_addr] <= we_data;
      rdat_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= ST_CLEAR;
         clr_ff   <= '0;
         out_v_ff <= 1'b0;
         cmd_ff   <= '0;
         init_ff  <= 1'b1;
      end else begin
         st_ff <= st_in;
         if (cmd_take) cmd_ff <= cmd_in;
         if (st_ff == ST_CLEAR) clr_ff <= clr_done ? '0 : clr_ff + AW'(1);
         if (st_ff == ST_DONE && !init_ff) out_v_ff <= 1'b1;
         else if (rsp_pop && out_v_ff) out_v_ff <= 1'b0;
         if (st_ff == ST_DONE) init_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_take) begin
         a_ff    <= 8'sd0;
         b_ff    <= 8'(cmd_in.radius);
         oct_ff  <= 3'd0;
         clip_ff <= 1'b0;
      end
      if (st_ff == ST_CIRC_PT && !on_scr && !circ_stop) clip_ff <= 1'b1;
      if (st_ff == ST_CIRC_STEP) begin
         oct_ff <= oct_ff + 3'd1;
         if (oct_ff == 3'd7) begin
            if (a1sq + bsq - rsq > 0) begin
               b_ff <= b_ff - 8'sd1;
            end else begin
               a_ff <= a1;
            end
         end
      end
      if (st_ff == ST_DONE) begin
         out_d_ff <= (cmd_ff.action == ACT_READ && on_scr) ? rdat_ff : 8'h00;
         out_c_ff <= (cmd_ff.action == ACT_CIRC) && clip_ff;
      end
   end

   property p_stall_result;
      @(posedge clock) disable iff (reset) (out_v_ff && !rsp_pop) |=> out_v_ff;
   endproperty
   a_stall_result: assert property (p_stall_result) else $error("result lost");

   property p_no_take_busy;
      @(posedge clock) disable iff (reset) cmd_take |-> st_ff == ST_IDLE;
   endproperty
   a_no_take_busy: assert property (p_no_take_busy) else $error("take while busy");

   property p_write_guard;
      @(posedge clock) disable iff (reset) (mem_we && st_ff == ST_CIRC_WR) |-> $past(on_scr);
   endproperty
   a_write_guard: assert property (p_write_guard) else $error("offscreen write");
endmodule

// ===== sv/page_framebuffer_plotter.sv =====
// from accept to result beat: set/clear pixel passes pixel read, pixel write and done states,
// read byte pixel read and done, unused action done only; circle: each mirrored point takes a
// point state, a write state when on screen and a step state; clear all walks every byte address, one per cycle
// throughput: one item at a time; the next starts the cycle after the result beat is popped
// reset is synchronous; a clearing pass over every byte address follows, the queue still fills
module page_framebuffer_plotter #(
   parameter int NUM_COLUMNS = 128,
   parameter int NUM_PAGES   = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [2:0] req_action,
   input  logic [6:0] req_x_pos,
   input  logic [5:0] req_y_pos,
   input  logic [5:0] req_radius,
   input  logic [2:0] req_page_sel,
   output logic       empty,
   input  logic       pop,
   output logic [7:0] rsp_read_data,
   output logic       rsp_clipped
);
   import pfp_pkg::*;

   cmd_type req_cmd, cmd;
   logic    cmd_valid, cmd_take;

   // pack the request beat
   assign req_cmd = '{action: req_action, x_pos: req_x_pos, y_pos: req_y_pos,
                      radius: req_radius, page_sel: req_page_sel};

   pfp_front u_front (
      .clock, .reset,
      .req_push(push), .req_full(full), .req_cmd,
      .cmd_valid, .cmd_take, .cmd_out(cmd)
   );

   pfp_back #(.NUM_COLUMNS(NUM_COLUMNS), .NUM_PAGES(NUM_PAGES)) u_back (
      .clock, .reset,
      .cmd_valid, .cmd_take, .cmd_in(cmd),
      .rsp_empty(empty), .rsp_pop(pop),
      .rsp_read_data, .rsp_clipped
   );
endmodule

// ===== tb/sv/tb_page_framebuffer_plotter.sv =====
module tb_page_framebuffer_plotter;
   timeunit 1ns;
   timeprecision 1ps;

   import pfp_pkg::*;

   localparam int NUM_COLUMNS = 128;
   localparam int NUM_PAGES   = 8;
   localparam int DRAIN_CYCLES = 3000;

   typedef struct packed {
      logic [7:0] read_data;
      logic       clipped;
   } frame_result_type;

   logic       clock;
   logic       reset;
   logic       push;
   logic       full;
   logic [2:0] req_action;
   logic [6:0] req_x_pos;
   logic [5:0] req_y_pos;
   logic [5:0] req_radius;
   logic [2:0] req_page_sel;
   logic       empty;
   logic       pop;
   logic [7:0] rsp_read_data;
   logic       rsp_clipped;

   // shadow copy of the framebuffer, column major
   logic [7:0] shadow_bytes [NUM_COLUMNS][NUM_PAGES];
   frame_result_type expected_beats[$];

   int error_count;
   int send_idle_pct;
   int pop_stall_pct;

   page_framebuffer_plotter #(
      .NUM_COLUMNS(NUM_COLUMNS),
      .NUM_PAGES  (NUM_PAGES)
   ) i_dut (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .req_action   (req_action),
      .req_x_pos    (req_x_pos),
      .req_y_pos    (req_y_pos),
      .req_radius   (req_radius),
      .req_page_sel (req_page_sel),
      .empty        (empty),
      .pop          (pop),
      .rsp_read_data(rsp_read_data),
      .rsp_clipped  (rsp_clipped)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // plot into the shadow store, returns 1 when the point lands on screen
   function automatic bit shadow_plot(int col, int row, bit on);
      int page;
      if (col < 0 || row < 0 || col >= NUM_COLUMNS) return 0;
      page = row >> 3;
      if (page >= NUM_PAGES) return 0;
      if (on) shadow_bytes[col][page][row & 7] = 1'b1;
      else shadow_bytes[col][page][row & 7] = 1'b0;
      return 1;
   endfunction

   // eight-way walk, stops once 2b^2 drops below r^2
   function automatic bit shadow_circle(int cx, int cy, int r);
      int a;
      int b;
      bit clip;
      a = 0;
      b = r;
      clip = 0;
      if (r == 0) return !shadow_plot(cx, cy, 1);
      while (2 * b * b >= r * r) begin
         clip |= !shadow_plot(cx + a, cy - b, 1);
         clip |= !shadow_plot(cx - a, cy - b, 1);
         clip |= !shadow_plot(cx - a, cy + b, 1);
         clip |= !shadow_plot(cx + a, cy + b, 1);
         clip |= !shadow_plot(cx + b, cy + a, 1);
         clip |= !shadow_plot(cx + b, cy - a, 1);
         clip |= !shadow_plot(cx - b, cy - a, 1);
         clip |= !shadow_plot(cx - b, cy + a, 1);
         a++;
         if (a * a + b * b - r * r > 0) begin
            b--;
            a--;
         end
      end
      return clip;
   endfunction

   function automatic frame_result_type predict_frame(cmd_type cmd);
      frame_result_type res;
      res = '0;
      case (cmd.action)
         ACT_SET: void'(shadow_plot(cmd.x_pos, cmd.y_pos, 1));
         ACT_CLR: void'(shadow_plot(cmd.x_pos, cmd.y_pos, 0));
         ACT_CLALL: begin
            foreach (shadow_bytes[c, p]) shadow_bytes[c][p] = '0;
         end
         ACT_CIRC: res.clipped = shadow_circle(cmd.x_pos, cmd.y_pos, cmd.radius);
         ACT_READ: begin
            if (cmd.x_pos < NUM_COLUMNS && cmd.page_sel < NUM_PAGES)
               res.read_data = shadow_bytes[cmd.x_pos][cmd.page_sel];
         end
         default: ;
      endcase
      return res;
   endfunction

   // drive one command beat, hold until accepted on a rising edge
   task automatic send_cmd(cmd_type cmd);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push         <= 1'b1;
      req_action   <= cmd.action;
      req_x_pos    <= cmd.x_pos;
      req_y_pos    <= cmd.y_pos;
      req_radius   <= cmd.radius;
      req_page_sel <= cmd.page_sel;
      do @(posedge clock); while (full);
      expected_beats.push_back(predict_frame(cmd));
      @(negedge clock);
   endtask

   function automatic cmd_type make_cmd(logic [2:0] act, int x, int y, int r, int pg);
      cmd_type cmd;
      cmd.action   = act;
      cmd.x_pos    = 7'(x);
      cmd.y_pos    = 6'(y);
      cmd.radius   = 6'(r);
      cmd.page_sel = 3'(pg);
      return cmd;
   endfunction

   // random commands, mostly reads and sets; radii mostly small, some drawn from the full range
   function automatic cmd_type random_cmd();
      cmd_type cmd;
      int pick;
      logic [31:0] raw;
      raw = $urandom;
      cmd = raw[$bits(cmd_type)-1:0];
      pick = $urandom_range(99);
      if (pick < 30) cmd.action = ACT_SET;
      else if (pick < 42) cmd.action = ACT_CLR;
      else if (pick < 43) cmd.action = ACT_CLALL;
      else if (pick < 55) cmd.action = ACT_CIRC;
      else if (pick < 95) cmd.action = ACT_READ;
      else cmd.action = 3'($urandom_range(7));
      if ($urandom_range(9) != 0) cmd.radius = 6'($urandom_range(12));
      return cmd;
   endfunction

   // pop side and result compare
   always @(posedge clock) begin
      frame_result_type want;
      if (!reset && pop && !empty) begin
         if (expected_beats.size() == 0) begin
            $display("%0t: unexpected beat read_data=%h clipped=%b", $time,
                     rsp_read_data, rsp_clipped);
            error_count++;
         end else begin
            want = expected_beats.pop_front();
            if (rsp_read_data !== want.read_data) begin
               $display("%0t: read_data expected %h actual %h", $time,
                        want.read_data, rsp_read_data);
               error_count++;
            end
            if (rsp_clipped !== want.clipped) begin
               $display("%0t: clipped expected %b actual %b", $time,
                        want.clipped, rsp_clipped);
               error_count++;
            end
         end
      end
   end

   always @(negedge clock) begin
      pop <= ($urandom_range(99) >= pop_stall_pct);
   end

   task automatic wait_drained();
      push <= 1'b0;
      while (expected_beats.size() != 0) @(negedge clock);
   endtask

   task automatic test_pixel_extremes();
      send_cmd(make_cmd(ACT_SET, 0, 0, 0, 0));
      send_cmd(make_cmd(ACT_SET, 127, 63, 63, 7));
      send_cmd(make_cmd(ACT_READ, 0, 0, 0, 0));
      send_cmd(make_cmd(ACT_READ, 127, 0, 0, 7));
      send_cmd(make_cmd(ACT_CLR, 127, 63, 0, 0));
      send_cmd(make_cmd(ACT_READ, 127, 63, 0, 7));
      send_cmd(make_cmd(ACT_SET, 5, 9, 0, 0));
      send_cmd(make_cmd(ACT_READ, 5, 0, 0, 1));
   endtask

   task automatic test_circles();
      // zero radius on screen, then a centre that lands on the corner
      send_cmd(make_cmd(ACT_CIRC, 64, 32, 0, 0));
      send_cmd(make_cmd(ACT_READ, 64, 0, 0, 4));
      send_cmd(make_cmd(ACT_CIRC, 0, 0, 0, 0));
      // fully on screen, then clipped near two opposite corners, then largest
      send_cmd(make_cmd(ACT_CIRC, 64, 32, 20, 0));
      send_cmd(make_cmd(ACT_READ, 64, 0, 0, 1));
      send_cmd(make_cmd(ACT_CIRC, 2, 2, 10, 0));
      send_cmd(make_cmd(ACT_CIRC, 125, 61, 10, 0));
      send_cmd(make_cmd(ACT_CIRC, 127, 63, 63, 0));
      send_cmd(make_cmd(ACT_READ, 84, 0, 0, 4));
   endtask

   task automatic test_clear_and_unused();
      send_cmd(make_cmd(3'd5, 127, 63, 63, 7));
      send_cmd(make_cmd(3'd6, 1, 1, 1, 1));
      send_cmd(make_cmd(3'd7, 0, 0, 0, 0));
      send_cmd(make_cmd(ACT_CLALL, 0, 0, 0, 0));
      send_cmd(make_cmd(ACT_READ, 64, 0, 0, 4));
      send_cmd(make_cmd(ACT_READ, 127, 0, 0, 7));
   endtask

   task automatic test_random_phase(int idle_pct, int stall_pct, int beats);
      send_idle_pct = idle_pct;
      pop_stall_pct = stall_pct;
      repeat (beats) send_cmd(random_cmd());
   endtask

   initial begin
      error_count   = 0;
      send_idle_pct = 0;
      pop_stall_pct = 0;
      foreach (shadow_bytes[c, p]) shadow_bytes[c][p] = '0;
      reset        = 1'b1;
      push         = 1'b0;
      req_action   = '0;
      req_x_pos    = '0;
      req_y_pos    = '0;
      req_radius   = '0;
      req_page_sel = '0;
      pop          = 1'b0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      test_pixel_extremes();
      test_circles();
      test_clear_and_unused();
      // hold off until the block has handed back everything
      wait_drained();
      test_random_phase(0, 0, 400);
      test_random_phase(65, 0, 350);
      test_random_phase(0, 65, 350);
      test_random_phase(16, 16, 400);

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0 && expected_beats.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // watchdog, well past the slowest legal run
   initial begin
      #20ms;
      $display("== FAIL ==");
      $finish;
   end

endmodule
